### hdl/pot_pkg.sv
// Shared types and constants for the prescaled overflow timer.
package pot_pkg;

  // Run state codes.
  localparam logic [1:0] RS_OFF      = 2'd0;
  localparam logic [1:0] RS_TIMEOUT  = 2'd1;
  localparam logic [1:0] RS_INTERVAL = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_REPEAT_MODE = 2'd0;
  localparam logic [1:0] REG_PERIOD_SEC  = 2'd1;
  localparam logic [1:0] REG_PERIOD_VAL  = 2'd2;

  // Field widths.
  localparam int unsigned CODE_W = 4;
  localparam int unsigned DIV_W  = 14;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned OVF_W  = 15;
  localparam int unsigned SOVF_W = 14;

  // Clock rate the period ladder is written for.
  localparam int unsigned BASE_KHZ = 16000;
  // Microseconds per second, applied in seconds mode.
  localparam logic [31:0] USEC_PER_SEC = 32'd1000000;
  // ceil(2^32 / 125): exact floor division by 125 for operands below 2^25.
  localparam logic [25:0] RECIP_125 = 26'd34359739;

  // Cycles from a configuration write until the period pipeline is settled.
  localparam logic [2:0] SETTLE_CYCLES = 3'd4;

  // Prescaler code and counts taken by a start request.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [SOVF_W-1:0] ovf;
    logic [CNT_W-1:0]  rem;
  } period_plan_t;

  // One result item.
  typedef struct packed {
    logic              fired;
    logic              running;
    logic [CODE_W-1:0] code;
    logic [CNT_W-1:0]  count;
  } result_t;

endpackage

### hdl/prescaled_overflow_timer.sv
// Prescaled overflow timer: a long-period timer from a prescaler and an 8-bit counter.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request per CPU clock tick:
//   start_req_i, stop_i and tick_i. Output channel (out_valid_o / out_stall_i)
//   returns one result per request: fired, running, prescale code and counter.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes repeat mode (0),
//   seconds mode (1) and period value (2) by index; write only while idle.
// Results and throughput:
//   An accepted request's result is registered in the result register (or the
//   skid slot while the receiver stalls); one request per cycle is sustained
//   while nothing stalls, set by the single state update before that register.
//   The period plan (prescaler code, overflow count, remainder) is worked out
//   from the registers by a four-stage pipeline (scale, divide, seconds
//   multiply, threshold ladder); in_stall_o stays high after each configuration
//   write and after reset until that pipeline settles.
// Stalls:
//   A result register plus a one-entry skid buffer let one more request in
//   while the receiver stalls; after that in_stall_o stays high until the
//   receiver takes the held result. Reset clears the timer to off with all counts zero.
module prescaled_overflow_timer
  import pot_pkg::*;
#(
  parameter int unsigned CLOCK_KHZ = 16000
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              start_req_i,
  input  logic              stop_i,
  input  logic              tick_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              fired_o,
  output logic              running_o,
  output logic [CODE_W-1:0] prescale_select_o,
  output logic [CNT_W-1:0]  count_now_o,
  // configuration channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic        repeat_mode_q;
  logic        period_sec_q;
  logic [31:0] period_val_q;
  logic [2:0]  settle_q;
  logic        cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_mode_q <= 1'b0;
      period_sec_q  <= 1'b0;
      period_val_q  <= '0;
      settle_q      <= SETTLE_CYCLES;
    end else begin
      if (cfg_wr) begin
        case (cfg_index_i)
          REG_REPEAT_MODE: repeat_mode_q <= cfg_data_i[0];
          REG_PERIOD_SEC:  period_sec_q  <= cfg_data_i[0];
          REG_PERIOD_VAL:  period_val_q  <= cfg_data_i;
          default: ;
        endcase
        settle_q <= SETTLE_CYCLES;
      end else if (settle_q != 3'd0) begin
        settle_q <= settle_q - 3'd1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Period plan pipeline
  // ---------------------------------------------------------------------
  // Stage 1: scale by the clock rate (product wraps modulo 2^32).
  logic [31:0] s1_val_q, s1_prod_q;
  // Stage 2: divide the scaled product by 16000 (shift by 7, reciprocal of 125); bypassed at 16000 kHz.
  logic [31:0] s2_val_q;
  // Stage 3: seconds product (wraps modulo 2^32).
  logic [31:0] s3_val_q, s3_sec_q;
  // Stage 4: threshold ladder result.
  period_plan_t plan_q, plan_d;

  logic [24:0] div_num;
  logic [50:0] div_prod;
  logic [31:0] scaled;

  assign div_num  = s1_prod_q[31:7];
  assign div_prod = {26'd0, div_num} * {25'd0, RECIP_125};
  assign scaled   = (CLOCK_KHZ == BASE_KHZ) ? s1_val_q : {13'd0, div_prod[50:32]};

  always_ff @(posedge clk_i) begin
    s1_val_q  <= period_val_q;
    s1_prod_q <= 32'(CLOCK_KHZ) * period_val_q;
    s2_val_q  <= scaled;
    s3_val_q  <= s2_val_q;
    s3_sec_q  <= s2_val_q * USEC_PER_SEC;
    plan_q    <= plan_d;
  end

  // Pick the prescaler code by the highest set bit of the period; seconds mode always uses code 15.
  always_comb begin
    logic [31:0] v;
    logic [31:0] sh;
    logic [7:0]  lo;
    v  = s3_val_q;
    lo = v[7:0];
    sh = '0;
    plan_d = '0;
    if (period_sec_q) begin
      plan_d.code = 4'd15;
      plan_d.ovf  = s3_sec_q[31:18];
      plan_d.rem  = 8'd255 - s3_sec_q[17:10];
    end else if (v[31:18] != '0) begin
      plan_d.code = 4'd15;
      plan_d.ovf  = v[31:18];
      plan_d.rem  = 8'd255 - v[17:10];
    end else if (v[17:8] != '0) begin
      // ascending scan: the highest set bit wins
      for (int k = 8; k <= 17; k++) begin
        if (v[k]) begin
          sh          = v >> (k - 7);
          plan_d.code = CODE_W'(k - 2);
          plan_d.rem  = 8'd255 - sh[7:0];
        end
      end
    end else if (v[7]) begin
      plan_d.code = 4'd5;
      plan_d.rem  = 8'd0 - lo;
    end else if (v[6]) begin
      plan_d.code = 4'd4;
      plan_d.rem  = 8'd0 - {lo[6:0], 1'b0};
    end else if (v[5]) begin
      plan_d.code = 4'd3;
      plan_d.rem  = 8'd0 - {lo[5:0], 2'b0};
    end else if (v[4]) begin
      plan_d.code = 4'd2;
      plan_d.rem  = 8'd0 - {lo[4:0], 3'b0};
    end else begin
      plan_d.code = 4'd1;
      plan_d.rem  = 8'd0 - {lo[3:0], 4'b0};
    end
  end

  // ---------------------------------------------------------------------
  // Timer state
  // ---------------------------------------------------------------------
  logic [1:0]        run_state_q, run_state_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic [DIV_W-1:0]  prescale_div_q, prescale_div_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [OVF_W-1:0]  ovf_left_q, ovf_left_d;
  logic [CNT_W-1:0]  rem_left_q, rem_left_d;
  logic [SOVF_W-1:0] saved_ovf_q, saved_ovf_d;
  logic [CNT_W-1:0]  saved_rem_q, saved_rem_d;

  logic    skid_valid_q;
  logic    out_valid_q;
  result_t out_q, skid_q, res;
  logic    in_acc, out_acc;

  // Hold off requests while the plan settles or the skid slot is full.
  assign in_stall_o = skid_valid_q || (settle_q != 3'd0);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  always_comb begin
    logic [OVF_W-1:0] limit;
    logic [OVF_W-1:0] div_inc;
    run_state_d    = run_state_q;
    code_d         = code_q;
    prescale_div_d = prescale_div_q;
    count_d        = count_q;
    ovf_left_d     = ovf_left_q;
    rem_left_d     = rem_left_q;
    saved_ovf_d    = saved_ovf_q;
    saved_rem_d    = saved_rem_q;
    res            = '0;

    // Start: take the settled plan; ignore a zero period.
    if (in_acc && start_req_i && (period_val_q != '0)) begin
      code_d         = plan_q.code;
      saved_ovf_d    = plan_q.ovf;
      saved_rem_d    = plan_q.rem;
      ovf_left_d     = {1'b0, plan_q.ovf} + OVF_W'(1);
      rem_left_d     = plan_q.rem;
      count_d        = '0;
      prescale_div_d = '0;
      run_state_d    = repeat_mode_q ? RS_INTERVAL : RS_TIMEOUT;
    end

    // Stop wins over a start in the same request.
    if (in_acc && stop_i) begin
      run_state_d = RS_OFF;
    end

    limit   = (code_d == '0) ? OVF_W'(1) : (OVF_W'(1) << (code_d - CODE_W'(1)));
    div_inc = {1'b0, prescale_div_d} + OVF_W'(1);

    // Advance the prescaler, then the counter; on a wrap count overflows down.
    if (in_acc && tick_i && (run_state_d != RS_OFF)) begin
      if (div_inc >= limit) begin
        prescale_div_d = '0;
        count_d        = count_d + CNT_W'(1);
        if (count_d == '0) begin
          if (ovf_left_d != '0) begin
            ovf_left_d = ovf_left_d - OVF_W'(1);
          end
          if (ovf_left_d == '0) begin
            if (rem_left_d != '0) begin
              count_d    = rem_left_d;
              rem_left_d = '0;
            end else begin
              res.fired = 1'b1;
              if (run_state_d == RS_TIMEOUT) begin
                run_state_d = RS_OFF;
              end else if (saved_ovf_d == '0) begin
                count_d    = saved_rem_d;
                rem_left_d = '0;
              end else begin
                ovf_left_d = {1'b0, saved_ovf_d};
                rem_left_d = saved_rem_d;
              end
            end
          end
        end
      end else begin
        prescale_div_d = div_inc[DIV_W-1:0];
      end
    end

    res.running = (run_state_d != RS_OFF);
    res.code    = code_d;
    res.count   = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_state_q    <= RS_OFF;
      code_q         <= '0;
      prescale_div_q <= '0;
      count_q        <= '0;
      ovf_left_q     <= '0;
      rem_left_q     <= '0;
      saved_ovf_q    <= '0;
      saved_rem_q    <= '0;
    end else begin
      run_state_q    <= run_state_d;
      code_q         <= code_d;
      prescale_div_q <= prescale_div_d;
      count_q        <= count_d;
      ovf_left_q     <= ovf_left_d;
      rem_left_q     <= rem_left_d;
      saved_ovf_q    <= saved_ovf_d;
      saved_rem_q    <= saved_rem_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register and skid slot
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_acc) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_acc;
        end
      end else if (in_acc) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_acc) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_acc) begin
      skid_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign fired_o           = out_q.fired;
  assign running_o         = out_q.running;
  assign prescale_select_o = out_q.code;
  assign count_now_o       = out_q.count;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  logic [OVF_W-1:0] cur_limit;
  assign cur_limit = (code_q == '0) ? OVF_W'(1) : (OVF_W'(1) << (code_q - CODE_W'(1)));

  // The skid slot is only used behind a held result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot full with empty result register");

  // After every accepted request the result register holds a valid result on the next cycle.
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted request produced no result");

  // The prescaler count stays below its divisor while running.
  a_div_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_state_q != RS_OFF) |-> ({1'b0, prescale_div_q} < cur_limit))
    else $error("prescaler count out of range");

endmodule

### dv/prescaled_overflow_timer_tb.sv
// Self-checking testbench for the prescaled overflow timer: directed and random requests.
`timescale 1ns / 1ps

module prescaled_overflow_timer_tb;
  import pot_pkg::*;

  // Clock rate the block is built for; the period is rescaled when it differs.
  localparam int unsigned CLK_KHZ = 16000;
  // Hard ceiling on the run; far beyond the slowest correct run.
  localparam int unsigned CYCLE_LIMIT = 1000000;
  // Length of the one long receiver hold-off that fills the block.
  localparam int unsigned RX_HOLD_LEN = 120;
  // Extra cycles at the end to catch stray results.
  localparam int unsigned DRAIN_CYCLES = 16;

  // One request: the three flags of one CPU clock step.
  typedef struct packed {
    logic start;
    logic stop;
    logic tick;
  } timer_req_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              start_req_i = 1'b0;
  logic              stop_i = 1'b0;
  logic              tick_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              fired_o;
  logic              running_o;
  logic [CODE_W-1:0] prescale_select_o;
  logic [CNT_W-1:0]  count_now_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = REG_REPEAT_MODE;
  logic [31:0]       cfg_data_i = 32'd0;

  prescaled_overflow_timer #(
    .CLOCK_KHZ(CLK_KHZ)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .start_req_i      (start_req_i),
    .stop_i           (stop_i),
    .tick_i           (tick_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .fired_o          (fired_o),
    .running_o        (running_o),
    .prescale_select_o(prescale_select_o),
    .count_now_o      (count_now_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Timer predictor: register copies and timer state, updated per request.
  // ---------------------------------------------------------------------------
  logic              tmr_repeat = 1'b0;
  logic              tmr_seconds = 1'b0;
  logic [31:0]       tmr_period = 32'd0;

  logic [1:0]        tmr_state = RS_OFF;
  logic [CODE_W-1:0] tmr_code = '0;
  logic [DIV_W-1:0]  tmr_div = '0;
  logic [CNT_W-1:0]  tmr_count = '0;
  logic [OVF_W-1:0]  tmr_ovf_left = '0;
  logic [CNT_W-1:0]  tmr_rem_left = '0;
  logic [SOVF_W-1:0] tmr_ovf_saved = '0;
  logic [CNT_W-1:0]  tmr_rem_saved = '0;

  // Work out prescaler code, overflow count and remainder, then arm the timer.
  function automatic void arm_timer();
    logic [31:0]       v;
    logic [31:0]       p;
    logic [31:0]       ovf;
    logic [31:0]       rem;
    logic [CODE_W-1:0] code;
    int unsigned       k;
    v = tmr_period;
    // A zero period leaves everything as it was.
    if (v == 32'd0) return;
    if (CLK_KHZ != BASE_KHZ) v = (32'(CLK_KHZ) * v) / BASE_KHZ;
    ovf = 32'd0;
    if (tmr_seconds) begin
      // Product wraps at 32 bits, then the largest divisor is used.
      p    = v * USEC_PER_SEC;
      code = 4'd15;
      ovf  = p >> 18;
      rem  = 32'd255 - (32'(p[17:0]) >> 10);
    end else if (v >= 32'd262144) begin
      code = 4'd15;
      ovf  = v >> 18;
      rem  = 32'd255 - (32'(v[17:0]) >> 10);
    end else if (v >= 32'd256) begin
      // Pick the highest set bit between 8 and 17; divisor 2^(k-7).
      k = 17;
      while (k > 8 && v < (32'd1 << k)) k--;
      code = 4'(k - 2);
      rem  = 32'd255 - (v >> (k - 7));
    end else if (v < 32'd16) begin
      code = 4'd1;
      rem  = (32'd256 - v * 32'd16) & 32'hFF;
    end else begin
      k = 7;
      while (k > 4 && v < (32'd1 << k)) k--;
      code = 4'(k - 2);
      rem  = (32'd256 - v * (32'd1 << (7 - k))) & 32'hFF;
    end
    tmr_code      = code;
    tmr_ovf_saved = ovf[SOVF_W-1:0];
    tmr_rem_saved = rem[CNT_W-1:0];
    tmr_ovf_left  = OVF_W'(tmr_ovf_saved) + 1'b1;
    tmr_rem_left  = tmr_rem_saved;
    tmr_count     = '0;
    tmr_div       = '0;
    tmr_state     = tmr_repeat ? RS_INTERVAL : RS_TIMEOUT;
  endfunction

  // Handle a counter wrap; return high when the period completes.
  function automatic logic take_wrap();
    if (tmr_ovf_left != '0) tmr_ovf_left--;
    if (tmr_ovf_left != '0) return 1'b0;
    // Overflows done: preload the remainder before the final stretch.
    if (tmr_rem_left != '0) begin
      tmr_count    = tmr_rem_left;
      tmr_rem_left = '0;
      return 1'b0;
    end
    if (tmr_state == RS_TIMEOUT) begin
      tmr_state = RS_OFF;
    end else if (tmr_ovf_saved == '0) begin
      tmr_count    = tmr_rem_saved;
      tmr_rem_left = '0;
    end else begin
      tmr_ovf_left = OVF_W'(tmr_ovf_saved);
      tmr_rem_left = tmr_rem_saved;
    end
    return 1'b1;
  endfunction

  // Apply one request (start, then stop, then tick) and return the result.
  function automatic result_t advance_timer(timer_req_t req);
    result_t     res;
    logic        hit;
    logic [31:0] limit;
    logic [31:0] nxt;
    hit = 1'b0;
    if (req.start) arm_timer();
    if (req.stop) tmr_state = RS_OFF;
    if (req.tick && tmr_state != RS_OFF) begin
      limit = (tmr_code != '0) ? (32'd1 << (tmr_code - 4'd1)) : 32'd1;
      nxt   = 32'(tmr_div) + 32'd1;
      if (nxt >= limit) begin
        tmr_div   = '0;
        tmr_count = tmr_count + 1'b1;
        if (tmr_count == '0) hit = take_wrap();
      end else begin
        tmr_div = nxt[DIV_W-1:0];
      end
    end
    res.fired   = hit;
    res.running = (tmr_state != RS_OFF);
    res.code    = tmr_code;
    res.count   = tmr_count;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping.
  // ---------------------------------------------------------------------------
  timer_req_t  pending_reqs[$];
  result_t     expected_results[$];
  int unsigned reqs_issued = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  logic        req_taken = 1'b0;
  logic        idle_on = 1'b1;
  logic        rx_hold_go = 1'b0;
  logic        rx_hold_done = 1'b0;
  int unsigned rx_hold_count = 0;
  int unsigned rx_stall_left = 0;
  int unsigned tx_gap_left = 0;
  timer_req_t  next_req;
  result_t     want;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(19) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: change inputs on the falling edge, hold a stalled request.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      if (tx_gap_left > 0) begin
        tx_gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        next_req = pending_reqs.pop_front();
        start_req_i <= next_req.start;
        stop_i      <= next_req.stop;
        tick_i      <= next_req.tick;
        in_valid_i  <= 1'b1;
        // While idling is on, insert a gap after roughly a third of the requests.
        if (idle_on && $urandom_range(2) == 0) tx_gap_left = pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: one long hold-off on request, random bursts otherwise while idling is on.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (rx_hold_go && !rx_hold_done) begin
      // Hold the output long enough for the block to stall its input.
      out_stall_i <= 1'b1;
      rx_hold_count++;
      if (rx_hold_count >= RX_HOLD_LEN) rx_hold_done = 1'b1;
    end else if (!idle_on) begin
      out_stall_i <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(3) == 0) begin
      rx_stall_left = pick_gap() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each accepted request, check each accepted result.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(advance_timer('{start_req_i, stop_i, tick_i}));
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with no request pending: fired %0d running %0d code %0d count %0d",
                 fired_o, running_o, prescale_select_o, count_now_o);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (fired_o !== want.fired) begin
            $error("fired: expected %0d, got %0d", want.fired, fired_o);
            fail_count++;
          end
          if (running_o !== want.running) begin
            $error("running: expected %0d, got %0d", want.running, running_o);
            fail_count++;
          end
          if (prescale_select_o !== want.code) begin
            $error("prescale_select: expected %0d, got %0d", want.code, prescale_select_o);
            fail_count++;
          end
          if (count_now_o !== want.count) begin
            $error("count_now: expected %0d, got %0d", want.count, count_now_o);
            fail_count++;
          end
        end
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("prescaled_overflow_timer_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer helpers.
  // ---------------------------------------------------------------------------

  // Queue one request for the driver.
  task automatic send(logic start, logic stop, logic tick);
    pending_reqs.push_back('{start, stop, tick});
    reqs_issued++;
  endtask

  // Wait until every queued request has produced its result.
  task automatic wait_idle();
    do @(negedge clk_i); while (results_seen != reqs_issued || pending_reqs.size() != 0);
  endtask

  // Write one register and mirror it in the predictor at the handshake.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_REPEAT_MODE: tmr_repeat  = data[0];
      REG_PERIOD_SEC:  tmr_seconds = data[0];
      REG_PERIOD_VAL:  tmr_period  = data;
      default: ;
    endcase
  endtask

  // Program all three registers; only called while idle.
  task automatic program_timer(logic rep, logic sec, logic [31:0] val);
    write_reg(REG_REPEAT_MODE, {31'd0, rep});
    write_reg(REG_PERIOD_SEC, {31'd0, sec});
    write_reg(REG_PERIOD_VAL, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Queue a well-formed run: a start if lead_start is set, then mostly ticks with rare restarts and stops.
  task automatic queue_requests(int unsigned n, int unsigned start_one_in,
                                int unsigned stop_one_in, logic lead_start);
    logic st;
    logic sp;
    for (int unsigned i = 0; i < n; i++) begin
      st = (i == 0 && lead_start) ||
           (start_one_in != 0 && $urandom_range(start_one_in - 1) == 0);
      sp = (i != 0) && stop_one_in != 0 && $urandom_range(stop_one_in - 1) == 0;
      send(st, sp, $urandom_range(9) != 0);
    end
  endtask

  // One random phase: program while idle, then stream requests.
  task automatic run_phase(logic rep, logic sec, logic [31:0] val, int unsigned n,
                           int unsigned start_one_in, int unsigned stop_one_in,
                           logic squeeze, logic pause);
    wait_idle();
    program_timer(rep, sec, val);
    if (pause) begin
      // Let the first half drain completely before the sender resumes.
      queue_requests(n / 2, start_one_in, stop_one_in, 1'b1);
      wait_idle();
      queue_requests(n - n / 2, start_one_in, stop_one_in, 1'b0);
    end else begin
      queue_requests(n, start_one_in, stop_one_in, 1'b1);
      if (squeeze) rx_hold_go = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  logic [31:0] edge_periods[11] = '{32'd1, 32'd15, 32'd16, 32'd127, 32'd128, 32'd255,
                                    32'd256, 32'd510, 32'd262143, 32'd262144,
                                    32'hFFFF_FFFF};

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero period after reset: start is dropped; stop and tick while off.
    wait_idle();
    send(1'b1, 1'b0, 1'b1);
    send(1'b0, 1'b1, 1'b0);
    send(1'b0, 1'b0, 1'b1);

    // Start and stop together end off; then start with a tick, stop, and
    // check that ticks leave the frozen counter alone.
    wait_idle();
    program_timer(1'b1, 1'b0, 32'd1);
    send(1'b1, 1'b1, 1'b1);
    send(1'b1, 1'b0, 1'b1);
    send(1'b0, 1'b1, 1'b0);
    send(1'b0, 1'b0, 1'b1);

    // Walk the threshold ladder across its boundaries, both modes.
    foreach (edge_periods[i]) begin
      wait_idle();
      program_timer(i[0], 1'b0, edge_periods[i]);
      send(1'b1, 1'b0, 1'b1);
    end

    // Seconds mode at both ends, including the wrapping product.
    wait_idle();
    program_timer(1'b1, 1'b1, 32'd1);
    send(1'b1, 1'b0, 1'b1);
    wait_idle();
    program_timer(1'b0, 1'b1, 32'hFFFF_FFFF);
    send(1'b1, 1'b0, 1'b1);

    // Short interval periods: frequent firing, plus the long receiver hold-off.
    run_phase(1'b1, 1'b0, $urandom_range(1, 6), 300, 0, 0, 1'b1, 1'b0);

    // Short timeouts with restarts and stops, no idling, one sender pause.
    idle_on = 1'b0;
    run_phase(1'b0, 1'b0, $urandom_range(1, 3), 300, 120, 150, 1'b0, 1'b1);

    // Zero remainder with divisor two: fire straight off the wrap.
    idle_on = 1'b1;
    run_phase(1'b1, 1'b0, 32'd510 + $urandom_range(1), 560, 0, 0, 1'b0, 1'b0);

    // Mid-ladder codes with restarts and stops.
    run_phase(1'($urandom_range(1)), 1'b0, $urandom_range(16, 255), 250, 60, 80, 1'b0, 1'b0);

    // Full-range periods in both units and the divided branch.
    idle_on = 1'b0;
    run_phase(1'($urandom_range(1)), 1'b0, $urandom, 60, 20, 30, 1'b0, 1'b0);
    idle_on = 1'b1;
    run_phase(1'($urandom_range(1)), 1'b1, $urandom, 60, 20, 30, 1'b0, 1'b0);
    run_phase(1'b1, 1'b0, $urandom_range(256, 262143), 60, 20, 30, 1'b0, 1'b0);

    // Drain, then watch a little longer for stray results.
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("prescaled_overflow_timer_tb: PASS");
    end else begin
      $display("prescaled_overflow_timer_tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/pot_pkg.sv
hdl/prescaled_overflow_timer.sv
dv/prescaled_overflow_timer_tb.sv
